/* rtl/pts_pkg.sv */
// types, codes and sizes shared by the task scheduler modules
// no dependencies
package pts_pkg;

    localparam int SLOTS   = 64;
    localparam int SLOT_W  = 6;
    localparam int LEVELS  = 32;
    localparam int LEVEL_W = 5;
    localparam int CNT_W   = 7;
    localparam int KEY_W   = 8;
    localparam int DATA_W  = 32;

    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [LEVEL_W-1:0] level_t;

    localparam logic [2:0] OP_ADD      = 3'd0;
    localparam logic [2:0] OP_REMOVE   = 3'd1;
    localparam logic [2:0] OP_BLOCK    = 3'd2;
    localparam logic [2:0] OP_UNBLOCK  = 3'd3;
    localparam logic [2:0] OP_BLKCUR   = 3'd4;
    localparam logic [2:0] OP_WAKE_EXT = 3'd5;
    localparam logic [2:0] OP_WAKE_EVT = 3'd6;
    localparam logic [2:0] OP_SCHED    = 3'd7;

    localparam logic [2:0] ST_UNUSED  = 3'd0;
    localparam logic [2:0] ST_READY   = 3'd1;
    localparam logic [2:0] ST_ACTIVE  = 3'd2;
    localparam logic [2:0] ST_BLOCKED = 3'd3;
    localparam logic [2:0] ST_TERM    = 3'd4;

    localparam logic [1:0] K_DONE  = 2'd0;
    localparam logic [1:0] K_SCHED = 2'd1;
    localparam logic [1:0] K_WOKEN = 2'd2;
    localparam logic [1:0] K_EMPTY = 2'd3;

    localparam logic [1:0] RSN_EXIT  = 2'd0;
    localparam logic [1:0] RSN_EVENT = 2'd1;

    typedef struct packed {
        logic [2:0]       status;
        level_t           level;
        logic [1:0]       reason;
        logic [KEY_W-1:0] key;
        slot_t            rnext;
        slot_t            rprev;
        slot_t            wnext;
        slot_t            wprev;
    } slot_ent_t;

    typedef struct packed {
        logic status;
        logic level;
        logic reason;
        logic key;
        logic rnext;
        logic rprev;
        logic wnext;
        logic wprev;
    } slot_we_t;

    typedef struct packed {
        slot_we_t  we;
        slot_t     addr;
        slot_ent_t data;
    } slot_wr_t;

    typedef struct packed {
        slot_t head;
        slot_t tail;
    } lvl_ent_t;

    typedef struct packed {
        logic     we_head;
        logic     we_tail;
        level_t   addr;
        lvl_ent_t data;
    } lvl_wr_t;

    typedef struct packed {
        logic [1:0]               kind;
        slot_t                    task_id;
        logic signed [DATA_W-1:0] data;
        logic                     last;
    } res_t;

endpackage

/* rtl/pts_ifs.sv */
// request and result channel interfaces of the task scheduler
// depends on pts_pkg
interface pts_cmd_if;
    logic                                  valid;
    logic                                  ready;
    logic [2:0]                            operation;
    logic [pts_pkg::SLOT_W-1:0]            task_id;
    logic [pts_pkg::LEVEL_W-1:0]           priority_req;
    logic [1:0]                            blk_cause;
    logic [pts_pkg::KEY_W-1:0]             wait_key;
    logic signed [pts_pkg::DATA_W-1:0]     evt_value;

    modport source (
        output valid, operation, task_id, priority_req, blk_cause, wait_key, evt_value,
        input  ready
    );
    modport sink (
        input  valid, operation, task_id, priority_req, blk_cause, wait_key, evt_value,
        output ready
    );
endinterface

interface pts_res_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            result_kind;
    logic [pts_pkg::SLOT_W-1:0]            result_task;
    logic signed [pts_pkg::DATA_W-1:0]     result_data;
    logic                                  last;

    modport source (
        output valid, result_kind, result_task, result_data, last,
        input  ready
    );
    modport sink (
        input  valid, result_kind, result_task, result_data, last,
        output ready
    );
endinterface

/* rtl/pts_slot_store.sv */
// per-slot memory: status, level, block info and both list links
// depends on pts_pkg; one read and one field-masked write per cycle
module pts_slot_store (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rd_en,
    input  pts_pkg::slot_t     rd_addr,
    output pts_pkg::slot_ent_t rd_data,
    input  pts_pkg::slot_wr_t  wr
);

    pts_pkg::slot_ent_t          ram [pts_pkg::SLOTS];
    logic [pts_pkg::SLOTS-1:0]   vld_reg;
    pts_pkg::slot_ent_t          rd_data_reg;
    logic                        rd_vld_reg;

    // a slot never given a status reads as unused
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr.we.status)
        begin
            vld_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.we.status) ram[wr.addr].status <= wr.data.status;
        if (wr.we.level)  ram[wr.addr].level  <= wr.data.level;
        if (wr.we.reason) ram[wr.addr].reason <= wr.data.reason;
        if (wr.we.key)    ram[wr.addr].key    <= wr.data.key;
        if (wr.we.rnext)  ram[wr.addr].rnext  <= wr.data.rnext;
        if (wr.we.rprev)  ram[wr.addr].rprev  <= wr.data.rprev;
        if (wr.we.wnext)  ram[wr.addr].wnext  <= wr.data.wnext;
        if (wr.we.wprev)  ram[wr.addr].wprev  <= wr.data.wprev;
        if (rd_en)
        begin
            rd_data_reg <= ram[rd_addr];
            rd_vld_reg  <= vld_reg[rd_addr];
        end
    end

    always_comb
    begin
        rd_data = rd_data_reg;
        if (!rd_vld_reg)
        begin
            rd_data.status = pts_pkg::ST_UNUSED;
        end
    end

endmodule

/* rtl/pts_level_store.sv */
// per-level memory holding head and tail of each ready queue
// depends on pts_pkg; one read and one write per cycle
module pts_level_store (
    input  logic              clk,
    input  logic              rd_en,
    input  pts_pkg::level_t   rd_addr,
    output pts_pkg::lvl_ent_t rd_data,
    input  pts_pkg::lvl_wr_t  wr
);

    pts_pkg::lvl_ent_t ram [pts_pkg::LEVELS];
    pts_pkg::lvl_ent_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we_head) ram[wr.addr].head <= wr.data.head;
        if (wr.we_tail) ram[wr.addr].tail <= wr.data.tail;
        if (rd_en)
        begin
            rd_data_reg <= ram[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/pts_seq.sv */
// command sequencer: walks the list updates with at most one access to each memory per cycle
// depends on pts_pkg, pts_ifs, and drives pts_slot_store / pts_level_store
module pts_seq (
    input  logic               clk,
    input  logic               rst_n,
    pts_cmd_if.sink            cmd,
    output logic               slot_rd_en,
    output pts_pkg::slot_t     slot_rd_addr,
    input  pts_pkg::slot_ent_t slot_rd,
    output pts_pkg::slot_wr_t  slot_wr,
    output logic               lvl_rd_en,
    output pts_pkg::level_t    lvl_rd_addr,
    input  pts_pkg::lvl_ent_t  lvl_rd,
    output pts_pkg::lvl_wr_t   lvl_wr,
    output logic               emit_valid,
    output pts_pkg::res_t      emit,
    input  logic               emit_ok
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_RD_T     = 5'd1;
    localparam logic [4:0] S_LD_T     = 5'd2;
    localparam logic [4:0] S_DET      = 5'd3;
    localparam logic [4:0] S_DET_RL   = 5'd4;
    localparam logic [4:0] S_DET_R2   = 5'd5;
    localparam logic [4:0] S_DET_W2   = 5'd6;
    localparam logic [4:0] S_RA       = 5'd7;
    localparam logic [4:0] S_RA2      = 5'd8;
    localparam logic [4:0] S_RA3      = 5'd9;
    localparam logic [4:0] S_WA       = 5'd10;
    localparam logic [4:0] S_WA2      = 5'd11;
    localparam logic [4:0] S_REM      = 5'd12;
    localparam logic [4:0] S_SCH_PICK = 5'd13;
    localparam logic [4:0] S_SCH_HD   = 5'd14;
    localparam logic [4:0] S_SCH_ACT  = 5'd15;
    localparam logic [4:0] S_WK_NODE  = 5'd16;
    localparam logic [4:0] S_WK_EMIT  = 5'd17;
    localparam logic [4:0] S_WK_END   = 5'd18;
    localparam logic [4:0] S_FIN      = 5'd19;

    // control
    logic [4:0]                        state_reg, state_next;
    logic [pts_pkg::LEVELS-1:0]        bitmap_reg, bitmap_next;
    logic [pts_pkg::CNT_W-1:0]         wc_reg, wc_next;
    logic                              run_vld_reg, run_vld_next;
    logic                              pend_vld_reg, pend_vld_next;
    // payload
    logic [2:0]                        op_reg, op_next;
    logic [pts_pkg::KEY_W-1:0]         key_reg, key_next;
    logic [1:0]                        rsn_reg, rsn_next;
    pts_pkg::level_t                   prio_reg, prio_next;
    logic signed [pts_pkg::DATA_W-1:0] wdata_reg, wdata_next;
    pts_pkg::slot_t                    t_reg, t_next;
    pts_pkg::slot_ent_t                ent_reg, ent_next;
    pts_pkg::level_t                   lvl_reg, lvl_next;
    pts_pkg::slot_t                    tail_reg, tail_next;
    pts_pkg::slot_t                    nxt_reg, nxt_next;
    logic [pts_pkg::CNT_W-1:0]         left_reg, left_next;
    logic                              phase_reg, phase_next;
    pts_pkg::slot_t                    wh_reg, wh_next;
    pts_pkg::slot_t                    wt_reg, wt_next;
    pts_pkg::slot_t                    run_task_reg, run_task_next;
    pts_pkg::slot_t                    pend_task_reg, pend_task_next;
    logic [1:0]                        fin_kind_reg, fin_kind_next;
    pts_pkg::slot_t                    fin_task_reg, fin_task_next;
    logic signed [pts_pkg::DATA_W-1:0] fin_data_reg, fin_data_next;

    logic [4:0]      det_done;
    logic [4:0]      ra_done;
    pts_pkg::level_t pick_idx;
    logic [1:0]      wake_rsn;
    logic            wake_hit;

    assign cmd.ready = (state_reg == S_IDLE);

    // where to go once the slot has left its list / has joined a ready queue
    always_comb
    begin
        unique case (op_reg)
            pts_pkg::OP_REMOVE: det_done = S_REM;
            pts_pkg::OP_BLOCK,
            pts_pkg::OP_BLKCUR: det_done = S_WA;
            pts_pkg::OP_SCHED:  det_done = S_SCH_ACT;
            default:            det_done = S_RA;
        endcase
        unique case (op_reg)
            pts_pkg::OP_WAKE_EXT,
            pts_pkg::OP_WAKE_EVT: ra_done = S_WK_EMIT;
            pts_pkg::OP_SCHED:    ra_done = S_SCH_PICK;
            default:              ra_done = S_FIN;
        endcase
    end

    // lowest-numbered non-empty level
    always_comb
    begin
        pick_idx = '0;
        for (int i = pts_pkg::LEVELS - 1; i >= 0; i--)
        begin
            if (bitmap_reg[i])
            begin
                pick_idx = pts_pkg::LEVEL_W'(i);
            end
        end
    end

    assign wake_rsn = (op_reg == pts_pkg::OP_WAKE_EVT) ? pts_pkg::RSN_EVENT : pts_pkg::RSN_EXIT;
    assign wake_hit = (slot_rd.status == pts_pkg::ST_BLOCKED) && (slot_rd.reason == wake_rsn)
                   && (slot_rd.key == key_reg);

    always_comb
    begin
        state_next     = state_reg;
        bitmap_next    = bitmap_reg;
        wc_next        = wc_reg;
        run_vld_next   = run_vld_reg;
        pend_vld_next  = pend_vld_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        rsn_next       = rsn_reg;
        prio_next      = prio_reg;
        wdata_next     = wdata_reg;
        t_next         = t_reg;
        ent_next       = ent_reg;
        lvl_next       = lvl_reg;
        tail_next      = tail_reg;
        nxt_next       = nxt_reg;
        left_next      = left_reg;
        phase_next     = phase_reg;
        wh_next        = wh_reg;
        wt_next        = wt_reg;
        run_task_next  = run_task_reg;
        pend_task_next = pend_task_reg;
        fin_kind_next  = fin_kind_reg;
        fin_task_next  = fin_task_reg;
        fin_data_next  = fin_data_reg;

        slot_rd_en   = 1'b0;
        slot_rd_addr = t_reg;
        slot_wr      = '0;
        lvl_rd_en    = 1'b0;
        lvl_rd_addr  = lvl_reg;
        lvl_wr       = '0;
        emit_valid   = 1'b0;
        emit         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next       = cmd.operation;
                    key_next      = cmd.wait_key;
                    rsn_next      = cmd.blk_cause;
                    prio_next     = cmd.priority_req;
                    wdata_next    = (cmd.operation == pts_pkg::OP_WAKE_EVT) ? cmd.evt_value : '0;
                    fin_kind_next = pts_pkg::K_DONE;
                    fin_task_next = '0;
                    fin_data_next = '0;
                    phase_next    = 1'b0;
                    unique case (cmd.operation)
                        pts_pkg::OP_BLKCUR,
                        pts_pkg::OP_SCHED:
                        begin
                            if (run_vld_reg)
                            begin
                                t_next       = run_task_reg;
                                run_vld_next = 1'b0;
                                state_next   = S_RD_T;
                            end
                            else
                            begin
                                state_next = (cmd.operation == pts_pkg::OP_SCHED) ? S_SCH_PICK
                                                                                  : S_FIN;
                            end
                        end
                        pts_pkg::OP_WAKE_EXT,
                        pts_pkg::OP_WAKE_EVT:
                        begin
                            left_next     = wc_reg;
                            t_next        = wh_reg;
                            pend_vld_next = 1'b0;
                            state_next    = S_WK_NODE;
                        end
                        default:
                        begin
                            t_next     = cmd.task_id;
                            state_next = S_RD_T;
                        end
                    endcase
                end
            end

            S_RD_T:
            begin
                slot_rd_en = 1'b1;
                state_next = S_LD_T;
            end

            S_LD_T:
            begin
                ent_next = slot_rd;
                nxt_next = slot_rd.wnext;
                lvl_next = (op_reg == pts_pkg::OP_ADD) ? prio_reg : slot_rd.level;
                unique case (op_reg)
                    pts_pkg::OP_ADD:
                        state_next = S_DET;
                    pts_pkg::OP_REMOVE,
                    pts_pkg::OP_BLOCK,
                    pts_pkg::OP_BLKCUR:
                        state_next = (slot_rd.status == pts_pkg::ST_UNUSED) ? S_FIN : S_DET;
                    pts_pkg::OP_UNBLOCK:
                        state_next = (slot_rd.status == pts_pkg::ST_BLOCKED) ? S_DET : S_FIN;
                    pts_pkg::OP_WAKE_EXT,
                    pts_pkg::OP_WAKE_EVT:
                    begin
                        if (wake_hit)
                        begin
                            state_next = S_DET;
                        end
                        else
                        begin
                            t_next     = slot_rd.wnext;
                            state_next = S_WK_NODE;
                        end
                    end
                    default:
                    begin
                        // first pass requeues the old current task, second unlinks the pick
                        if (phase_reg)
                            state_next = S_DET;
                        else if (slot_rd.status == pts_pkg::ST_ACTIVE)
                            state_next = S_RA;
                        else
                            state_next = S_SCH_PICK;
                    end
                endcase
            end

            S_DET:
            begin
                if (ent_reg.status == pts_pkg::ST_READY)
                begin
                    lvl_rd_en   = 1'b1;
                    lvl_rd_addr = ent_reg.level;
                    state_next  = S_DET_RL;
                end
                else if (ent_reg.status == pts_pkg::ST_BLOCKED)
                begin
                    state_next = det_done;
                    if (wc_reg <= pts_pkg::CNT_W'(1))
                    begin
                        wc_next = '0;
                    end
                    else
                    begin
                        wc_next = wc_reg - pts_pkg::CNT_W'(1);
                        if (wh_reg == t_reg)
                        begin
                            wh_next = ent_reg.wnext;
                        end
                        else if (wt_reg == t_reg)
                        begin
                            wt_next = ent_reg.wprev;
                        end
                        else
                        begin
                            slot_wr.we.wnext   = 1'b1;
                            slot_wr.addr       = ent_reg.wprev;
                            slot_wr.data.wnext = ent_reg.wnext;
                            state_next         = S_DET_W2;
                        end
                    end
                end
                else
                begin
                    state_next = det_done;
                end
            end

            S_DET_RL:
            begin
                state_next = det_done;
                lvl_wr.addr = ent_reg.level;
                if (lvl_rd.head == t_reg && lvl_rd.tail == t_reg)
                begin
                    bitmap_next[ent_reg.level] = 1'b0;
                end
                else if (lvl_rd.head == t_reg)
                begin
                    lvl_wr.we_head   = 1'b1;
                    lvl_wr.data.head = ent_reg.rnext;
                end
                else if (lvl_rd.tail == t_reg)
                begin
                    lvl_wr.we_tail   = 1'b1;
                    lvl_wr.data.tail = ent_reg.rprev;
                end
                else
                begin
                    slot_wr.we.rnext   = 1'b1;
                    slot_wr.addr       = ent_reg.rprev;
                    slot_wr.data.rnext = ent_reg.rnext;
                    state_next         = S_DET_R2;
                end
            end

            S_DET_R2:
            begin
                slot_wr.we.rprev   = 1'b1;
                slot_wr.addr       = ent_reg.rnext;
                slot_wr.data.rprev = ent_reg.rprev;
                state_next         = det_done;
            end

            S_DET_W2:
            begin
                slot_wr.we.wprev   = 1'b1;
                slot_wr.addr       = ent_reg.wnext;
                slot_wr.data.wprev = ent_reg.wprev;
                state_next         = det_done;
            end

            S_RA:
            begin
                if (bitmap_reg[lvl_reg])
                begin
                    lvl_rd_en   = 1'b1;
                    lvl_rd_addr = lvl_reg;
                    state_next  = S_RA2;
                end
                else
                begin
                    lvl_wr.we_head      = 1'b1;
                    lvl_wr.we_tail      = 1'b1;
                    lvl_wr.addr         = lvl_reg;
                    lvl_wr.data.head    = t_reg;
                    lvl_wr.data.tail    = t_reg;
                    bitmap_next[lvl_reg] = 1'b1;
                    slot_wr.we.status   = 1'b1;
                    slot_wr.we.level    = 1'b1;
                    slot_wr.addr        = t_reg;
                    slot_wr.data.status = pts_pkg::ST_READY;
                    slot_wr.data.level  = lvl_reg;
                    state_next          = ra_done;
                end
            end

            S_RA2:
            begin
                tail_next          = lvl_rd.tail;
                slot_wr.we.rnext   = 1'b1;
                slot_wr.addr       = lvl_rd.tail;
                slot_wr.data.rnext = t_reg;
                state_next         = S_RA3;
            end

            S_RA3:
            begin
                slot_wr.we.status   = 1'b1;
                slot_wr.we.level    = 1'b1;
                slot_wr.we.rprev    = 1'b1;
                slot_wr.addr        = t_reg;
                slot_wr.data.status = pts_pkg::ST_READY;
                slot_wr.data.level  = lvl_reg;
                slot_wr.data.rprev  = tail_reg;
                lvl_wr.we_tail      = 1'b1;
                lvl_wr.addr         = lvl_reg;
                lvl_wr.data.tail    = t_reg;
                state_next          = ra_done;
            end

            S_WA:
            begin
                if (wc_reg == '0)
                begin
                    wh_next = t_reg;
                end
                else
                begin
                    slot_wr.we.wnext   = 1'b1;
                    slot_wr.addr       = wt_reg;
                    slot_wr.data.wnext = t_reg;
                end
                state_next = S_WA2;
            end

            S_WA2:
            begin
                slot_wr.we.status   = 1'b1;
                slot_wr.we.reason   = 1'b1;
                slot_wr.we.key      = 1'b1;
                slot_wr.we.wprev    = 1'b1;
                slot_wr.addr        = t_reg;
                slot_wr.data.status = pts_pkg::ST_BLOCKED;
                slot_wr.data.reason = rsn_reg;
                slot_wr.data.key    = key_reg;
                slot_wr.data.wprev  = wt_reg;
                wt_next             = t_reg;
                wc_next             = wc_reg + pts_pkg::CNT_W'(1);
                state_next          = S_FIN;
            end

            S_REM:
            begin
                slot_wr.we.status   = 1'b1;
                slot_wr.addr        = t_reg;
                slot_wr.data.status = pts_pkg::ST_TERM;
                if (run_vld_reg && run_task_reg == t_reg)
                begin
                    run_vld_next = 1'b0;
                end
                state_next = S_FIN;
            end

            S_SCH_PICK:
            begin
                if (bitmap_reg == '0)
                begin
                    fin_kind_next = pts_pkg::K_EMPTY;
                    state_next    = S_FIN;
                end
                else
                begin
                    lvl_rd_en   = 1'b1;
                    lvl_rd_addr = pick_idx;
                    phase_next  = 1'b1;
                    state_next  = S_SCH_HD;
                end
            end

            S_SCH_HD:
            begin
                t_next     = lvl_rd.head;
                state_next = S_RD_T;
            end

            S_SCH_ACT:
            begin
                slot_wr.we.status   = 1'b1;
                slot_wr.addr        = t_reg;
                slot_wr.data.status = pts_pkg::ST_ACTIVE;
                run_vld_next        = 1'b1;
                run_task_next       = t_reg;
                fin_kind_next       = pts_pkg::K_SCHED;
                fin_task_next       = t_reg;
                state_next          = S_FIN;
            end

            S_WK_NODE:
            begin
                if (left_reg == '0)
                begin
                    state_next = S_WK_END;
                end
                else
                begin
                    left_next  = left_reg - pts_pkg::CNT_W'(1);
                    state_next = S_RD_T;
                end
            end

            // the previous woken task goes out once we know it is not the final one
            S_WK_EMIT:
            begin
                if (pend_vld_reg)
                begin
                    emit_valid   = 1'b1;
                    emit.kind    = pts_pkg::K_WOKEN;
                    emit.task_id = pend_task_reg;
                    emit.data    = wdata_reg;
                    emit.last    = 1'b0;
                end
                if (!pend_vld_reg || emit_ok)
                begin
                    pend_vld_next  = 1'b1;
                    pend_task_next = t_reg;
                    t_next         = nxt_reg;
                    state_next     = S_WK_NODE;
                end
            end

            S_WK_END:
            begin
                if (pend_vld_reg)
                begin
                    fin_kind_next = pts_pkg::K_WOKEN;
                    fin_task_next = pend_task_reg;
                    fin_data_next = wdata_reg;
                end
                state_next = S_FIN;
            end

            S_FIN:
            begin
                emit_valid   = 1'b1;
                emit.kind    = fin_kind_reg;
                emit.task_id = fin_task_reg;
                emit.data    = fin_data_reg;
                emit.last    = 1'b1;
                if (emit_ok)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            bitmap_reg   <= '0;
            wc_reg       <= '0;
            run_vld_reg  <= 1'b0;
            pend_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            bitmap_reg   <= bitmap_next;
            wc_reg       <= wc_next;
            run_vld_reg  <= run_vld_next;
            pend_vld_reg <= pend_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        rsn_reg       <= rsn_next;
        prio_reg      <= prio_next;
        wdata_reg     <= wdata_next;
        t_reg         <= t_next;
        ent_reg       <= ent_next;
        lvl_reg       <= lvl_next;
        tail_reg      <= tail_next;
        nxt_reg       <= nxt_next;
        left_reg      <= left_next;
        phase_reg     <= phase_next;
        wh_reg        <= wh_next;
        wt_reg        <= wt_next;
        run_task_reg  <= run_task_next;
        pend_task_reg <= pend_task_next;
        fin_kind_reg  <= fin_kind_next;
        fin_task_reg  <= fin_task_next;
        fin_data_reg  <= fin_data_next;
    end

endmodule

/* rtl/priority_task_scheduler.sv */
// top level of the priority task scheduler: sequencer, two memories, result register
// depends on pts_pkg, pts_ifs, pts_slot_store, pts_level_store, pts_seq
//
// usage:
//   cmd carries one request at a time (add, remove, block, unblock, block
//   current, wake on exit, wake on event, schedule); res returns one or more
//   results per request, the final one flagged by last.
//   cmd.ready is high only while the sequencer is idle, one request in flight.
//   a schedule requeues the current task and then unlinks the new one; a wake
//   walks the blocked list entry by entry, unlinking each task woken and
//   requeueing it at its level. the pace is set by the memories: one read
//   and one write each per cycle, each list relink costing up to one read
//   and up to two writes.
//   a result sits in an output register; a new request is taken while it waits.
//   if res stalls, the sequencer holds at its next result until the register
//   frees, so a long wake simply pauses.
//   reset: no slot in use, all queues and the blocked list empty, no current
//   task; memories need no clearing pass.
module priority_task_scheduler (
    input  logic      clk,
    input  logic      rst_n,
    pts_cmd_if.sink   cmd,
    pts_res_if.source res
);

    logic               slot_rd_en;
    pts_pkg::slot_t     slot_rd_addr;
    pts_pkg::slot_ent_t slot_rd;
    pts_pkg::slot_wr_t  slot_wr;
    logic               lvl_rd_en;
    pts_pkg::level_t    lvl_rd_addr;
    pts_pkg::lvl_ent_t  lvl_rd;
    pts_pkg::lvl_wr_t   lvl_wr;
    logic               emit_valid;
    pts_pkg::res_t      emit;
    logic               emit_ok;

    logic               out_vld_reg;
    pts_pkg::res_t      out_reg;

    pts_slot_store u_slot (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (slot_rd_en),
        .rd_addr (slot_rd_addr),
        .rd_data (slot_rd),
        .wr      (slot_wr)
    );

    pts_level_store u_level (
        .clk     (clk),
        .rd_en   (lvl_rd_en),
        .rd_addr (lvl_rd_addr),
        .rd_data (lvl_rd),
        .wr      (lvl_wr)
    );

    pts_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .slot_rd_en   (slot_rd_en),
        .slot_rd_addr (slot_rd_addr),
        .slot_rd      (slot_rd),
        .slot_wr      (slot_wr),
        .lvl_rd_en    (lvl_rd_en),
        .lvl_rd_addr  (lvl_rd_addr),
        .lvl_rd       (lvl_rd),
        .lvl_wr       (lvl_wr),
        .emit_valid   (emit_valid),
        .emit         (emit),
        .emit_ok      (emit_ok)
    );

    assign emit_ok = !out_vld_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (emit_valid && emit_ok)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_valid && emit_ok)
        begin
            out_reg <= emit;
        end
    end

    assign res.valid       = out_vld_reg;
    assign res.result_kind = out_reg.kind;
    assign res.result_task = out_reg.task_id;
    assign res.result_data = out_reg.data;
    assign res.last        = out_reg.last;

endmodule

/* rtl/pts_checker.sv */
// port-level checks of the task scheduler, bound to the top level
// depends on pts_pkg and priority_task_scheduler
module pts_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              cmd_valid,
    input logic                              cmd_ready,
    input logic                              res_valid,
    input logic                              res_ready,
    input logic [1:0]                        result_kind,
    input logic [pts_pkg::SLOT_W-1:0]        result_task,
    input logic signed [pts_pkg::DATA_W-1:0] result_data,
    input logic                              last
);

    // one request in flight: ready drops right after a request is taken
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("request taken while another is in flight");

    // only woken results can be followed by more results of the same request
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (result_kind != pts_pkg::K_WOKEN) |-> last)
        else $error("non-wake result without last");

    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (result_kind == pts_pkg::K_DONE || result_kind == pts_pkg::K_EMPTY)
        |-> (result_task == '0) && (result_data == '0))
        else $error("done or empty result carries task or data");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(result_kind) && $stable(result_task)
        && $stable(result_data) && $stable(last))
        else $error("stalled result changed");

endmodule

bind priority_task_scheduler pts_checker u_pts_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .result_kind (res.result_kind),
    .result_task (res.result_task),
    .result_data (res.result_data),
    .last        (res.last)
);
